// ----- rtl/kwm_pkg.sv -----
// kwm_pkg: shared types and constants for the k-way sorted merge
// used by kwm_cmp, kwm_heap and k_way_sorted_merge; no dependencies
package kwm_pkg;

  // fixed field widths
  localparam int LANE_W    = 4;
  localparam int CFG_W     = 5;
  localparam int LOAD_W    = 5;
  localparam logic [LOAD_W-1:0] LOAD_MAX  = 5'd31;
  localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;

  // heap sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_UP_CMP,
    S_PLACE,
    S_POP,
    S_POP_TOP,
    S_POP_LAST,
    S_DN_RD,
    S_DN_C0,
    S_DN_SEL,
    S_DN_CMP,
    S_RESP
  } heap_state_t;

  // request from the control side to the heap engine
  typedef struct packed {
    logic start;  // launch one operation
    logic ins;    // insert the supplied entry first
    logic pop;    // pop the minimum afterwards
  } heap_cmd_t;

  // status from the heap engine
  typedef struct packed {
    logic idle;   // ready for a new operation
    logic valid;  // operation finished, result held
    logic empty;  // pop found no entry
  } heap_rsp_t;

endpackage

// ----- rtl/kwm_cmp.sv -----
// kwm_cmp: ordering compare of two heap entries (value, then lane)
// depends on kwm_pkg
module kwm_cmp
  import kwm_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic signed [DATA_WIDTH-1:0] a_value,
  input  logic        [LANE_W-1:0]     a_lane,
  input  logic signed [DATA_WIDTH-1:0] b_value,
  input  logic        [LANE_W-1:0]     b_lane,
  output logic                         a_first
);

  // smaller value wins, equal values go to the lower lane
  always_comb begin
    if (a_value != b_value) begin
      a_first = (a_value < b_value);
    end else begin
      a_first = (a_lane < b_lane);
    end
  end

endmodule

// ----- rtl/kwm_heap.sv -----
// kwm_heap: min-heap engine, heap memory with one read and one write port, plus one shared comparator
// depends on kwm_pkg and kwm_cmp
module kwm_heap
  import kwm_pkg::*;
#(
  parameter int LANES      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  heap_cmd_t                    cmd,
  input  logic signed [DATA_WIDTH-1:0] cmd_value,
  input  logic        [LANE_W-1:0]     cmd_lane,
  input  logic                         rsp_ready,
  output heap_rsp_t                    rsp,
  output logic signed [DATA_WIDTH-1:0] res_value,
  output logic        [LANE_W-1:0]     res_lane
);

  localparam int IW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CW = $clog2(LANES + 1);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic        [LANE_W-1:0]     lane;
  } entry_t;

  heap_state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r;
  logic          pop_pend_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] best_idx_r;
  entry_t        hold_r;
  entry_t        best_r;
  entry_t        rd_data_r;
  logic          res_empty_r;
  logic signed [DATA_WIDTH-1:0] res_value_r;
  logic        [LANE_W-1:0]     res_lane_r;

  entry_t mem [LANES];

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [IW-1:0] mem_raddr;

  logic [IW-1:0] parent;
  logic [IW:0]   child;
  logic [IW:0]   child1;
  logic          ins_ok;
  entry_t        cmp_a, cmp_b;
  logic          a_first;

  assign parent = (idx_r - 1'b1) >> 1;
  assign child  = {idx_r, 1'b1};
  assign child1 = child + 1'b1;
  assign ins_ok = cmd.ins && (cnt_r < CW'(LANES));

  // shared comparator
  always_comb begin
    case (state_r)
      S_DN_SEL: begin
        cmp_a = rd_data_r;
        cmp_b = best_r;
      end
      S_DN_CMP: begin
        cmp_a = best_r;
        cmp_b = hold_r;
      end
      default: begin
        cmp_a = hold_r;
        cmp_b = rd_data_r;
      end
    endcase
  end

  kwm_cmp #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_cmp (
    .a_value (cmp_a.value),
    .a_lane  (cmp_a.lane),
    .b_value (cmp_b.value),
    .b_lane  (cmp_b.lane),
    .a_first (a_first)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          if (ins_ok) begin
            state_nxt = S_UP;
          end else if (cmd.pop) begin
            state_nxt = S_POP;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_UP:       state_nxt = (idx_r == '0) ? S_PLACE : S_UP_CMP;
      S_UP_CMP:   state_nxt = a_first ? S_UP : S_PLACE;
      S_PLACE:    state_nxt = pop_pend_r ? S_POP : S_RESP;
      S_POP:      state_nxt = (cnt_r == '0) ? S_RESP : S_POP_TOP;
      S_POP_TOP:  state_nxt = (cnt_r == '0) ? S_RESP : S_POP_LAST;
      S_POP_LAST: state_nxt = S_DN_RD;
      S_DN_RD:    state_nxt = (child < (IW+1)'(cnt_r)) ? S_DN_C0 : S_PLACE;
      S_DN_C0:    state_nxt = (child1 < (IW+1)'(cnt_r)) ? S_DN_SEL : S_DN_CMP;
      S_DN_SEL:   state_nxt = S_DN_CMP;
      S_DN_CMP:   state_nxt = a_first ? S_DN_RD : S_PLACE;
      S_RESP:     state_nxt = rsp_ready ? S_IDLE : S_RESP;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // memory controls and status
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = hold_r;
    mem_raddr = '0;
    rsp.idle  = 1'b0;
    rsp.valid = 1'b0;
    rsp.empty = res_empty_r;
    case (state_r)
      S_IDLE:    rsp.idle = 1'b1;
      S_UP:      mem_raddr = parent;
      S_UP_CMP: begin
        mem_we    = a_first;
        mem_wdata = rd_data_r;
      end
      S_PLACE:   mem_we = 1'b1;
      S_POP_TOP: mem_raddr = cnt_r[IW-1:0];
      S_DN_RD:   mem_raddr = child[IW-1:0];
      S_DN_C0:   mem_raddr = child1[IW-1:0];
      S_DN_CMP: begin
        mem_we    = a_first;
        mem_wdata = best_r;
      end
      S_RESP:    rsp.valid = 1'b1;
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  // heap storage, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      pop_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (cmd.start) begin
            pop_pend_r <= cmd.pop;
            if (ins_ok) begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        S_POP: begin
          pop_pend_r <= 1'b0;
          if (cnt_r != '0) begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (cmd.start && ins_ok) begin
          hold_r.value <= cmd_value;
          hold_r.lane  <= cmd_lane;
          idx_r        <= cnt_r[IW-1:0];
        end
      end
      S_UP_CMP: begin
        if (a_first) begin
          idx_r <= parent;
        end
      end
      S_POP: begin
        res_empty_r <= (cnt_r == '0);
        res_value_r <= '0;
        res_lane_r  <= '0;
      end
      S_POP_TOP: begin
        res_value_r <= rd_data_r.value;
        res_lane_r  <= rd_data_r.lane;
      end
      S_POP_LAST: begin
        hold_r <= rd_data_r;
        idx_r  <= '0;
      end
      S_DN_C0: begin
        best_r     <= rd_data_r;
        best_idx_r <= child[IW-1:0];
      end
      S_DN_SEL: begin
        if (a_first) begin
          best_r     <= rd_data_r;
          best_idx_r <= child1[IW-1:0];
        end
      end
      S_DN_CMP: begin
        if (a_first) begin
          idx_r <= best_idx_r;
        end
      end
      default: begin
        idx_r <= idx_r;
      end
    endcase
  end

  assign res_value = res_value_r;
  assign res_lane  = res_lane_r;

  // an accepted insert grows the heap by one
  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && cmd.start && ins_ok) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("heap count did not grow on insert");

  // a pop from a non-empty heap shrinks it by one
  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP && cnt_r != '0) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("heap count did not shrink on pop");

  // storage only changes while an operation runs
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != S_IDLE && state_r != S_RESP))
    else $error("heap written outside an operation");

endmodule

// ----- rtl/k_way_sorted_merge.sv -----
// k_way_sorted_merge: top level, stream ports, fill/merge bookkeeping, output register
// depends on kwm_pkg and kwm_heap
//
// channel | dir | handshake                 | payload
// --------+-----+---------------------------+------------------------------------
// in      | in  | in_tvalid / in_tready     | in_tdata {value, lane}, in_tuser lane_ended
// out     | out | out_tvalid / out_tready   | out_tdata {lane_res, value_res}, out_tuser done_res
// cfg     | in  | cfg_wr_en                 | cfg_wr_data lanes_in_use
//
// one transaction at a time: in_tready is high only while the heap engine is idle
// a transaction: accept, then the insert if any (climbing toward the root), then the pop if any (the
// last entry replaces the root and sinks level by level), then the hand-over of the result
// reset (rst_n low, synchronous) empties the heap, rearms the fill, lanes_in_use = 16
// a waiting result holds the next result in the engine until out_tready, and with it the input
module k_way_sorted_merge
  import kwm_pkg::*;
#(
  parameter int LANES      = 16,
  parameter int DATA_WIDTH = 32,
  localparam int IO_W      = ((DATA_WIDTH + LANE_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IO_W-1:0]       in_tdata,   // [3:0] lane, [DATA_WIDTH+3:4] value, rest zero
  input  logic                  in_tuser,   // [0] lane_ended
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [IO_W-1:0]       out_tdata,  // [DATA_WIDTH-1:0] value_res, next 4 lane_res
  output logic                  out_tuser,  // [0] done_res
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data // lanes_in_use
);

  // configuration register
  logic [CFG_W-1:0] lanes_cfg_r;

  // merge bookkeeping
  logic [LOAD_W-1:0] loaded_r;
  logic [LOAD_W-1:0] loaded_nxt;
  logic              merging_r;
  logic [LANE_W-1:0] last_lane_r;
  logic              need_res_r;

  // output register
  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] out_value_r;
  logic        [LANE_W-1:0]     out_lane_r;
  logic                         out_done_r;

  // input fields
  logic        [LANE_W-1:0]     in_lane;
  logic signed [DATA_WIDTH-1:0] in_value;
  logic                         in_acc;

  // heap engine link
  heap_cmd_t                    cmd;
  heap_rsp_t                    rsp;
  logic                         rsp_ready;
  logic signed [DATA_WIDTH-1:0] res_value;
  logic        [LANE_W-1:0]     res_lane;
  logic        [CFG_W-1:0]      cfg_min1;
  logic                         fill_done;
  logic                         rsp_take;

  assign in_lane  = in_tdata[LANE_W-1:0];
  assign in_value = in_tdata[LANE_W +: DATA_WIDTH];
  assign in_tready = rsp.idle;
  assign in_acc    = in_tvalid && in_tready;

  // saturating report count; fill ends at max(lanes_in_use, 1) capped at LANES
  assign loaded_nxt = (loaded_r == LOAD_MAX) ? loaded_r : loaded_r + 1'b1;
  assign cfg_min1   = (lanes_cfg_r == '0) ? CFG_W'(1) : lanes_cfg_r;
  assign fill_done  = (loaded_nxt >= cfg_min1) || (32'(loaded_nxt) >= LANES);

  // fill phase inserts under the given lane, merge phase refills the popped lane; lane_ended skips the insert
  always_comb begin
    cmd.start = in_acc;
    cmd.ins   = !in_tuser;
    cmd.pop   = merging_r || fill_done;
  end

  assign rsp_ready = !need_res_r || !out_valid_r || out_tready;
  assign rsp_take  = rsp.valid && rsp_ready;

  kwm_heap #(
    .LANES      (LANES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_heap (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_value (in_value),
    .cmd_lane  (merging_r ? last_lane_r : in_lane),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .res_value (res_value),
    .res_lane  (res_lane)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lanes_cfg_r <= CFG_RESET;
      loaded_r    <= '0;
      merging_r   <= 1'b0;
      last_lane_r <= '0;
      need_res_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lanes_cfg_r <= cfg_wr_data;
      end
      // bookkeeping at the start of a transaction
      if (in_acc) begin
        need_res_r <= cmd.pop;
        if (!merging_r) begin
          loaded_r  <= loaded_nxt;
          merging_r <= fill_done;
        end
      end
      // heap result handed over
      if (rsp_take && need_res_r) begin
        if (rsp.empty) begin
          // all lanes drained: rearm for the next fill
          loaded_r    <= '0;
          merging_r   <= 1'b0;
          last_lane_r <= '0;
        end else begin
          last_lane_r <= res_lane;
        end
      end
      // output slot
      if (rsp_take && need_res_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (rsp_take && need_res_r) begin
      out_value_r <= res_value;
      out_lane_r  <= res_lane;
      out_done_r  <= rsp.empty;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = IO_W'({out_lane_r, out_value_r});
  assign out_tuser  = out_done_r;

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input taken while an operation is in flight");

  // a handed-over result lands in the output register
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_take && need_res_r) |=> out_valid_r)
    else $error("heap result lost");

  // a done result carries a zero payload
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> (out_value_r == '0 && out_lane_r == '0))
    else $error("done result with nonzero payload");

  // a non-empty pop result is handed over only in the merge phase
  a_no_stray_merge: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_take && need_res_r && !rsp.empty) |-> merging_r)
    else $error("pop result outside the merge phase");

endmodule
